// ----- rtl/amq_pkg.sv -----
// ----------------------------------------------------------------------------
// amq_pkg
// Shared types, constants and saturating fixed-point helpers for the
// accelerometer/magnetometer to quaternion pipeline.
// ----------------------------------------------------------------------------
package amq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // divider numerator width, square-root result width and its working widths
  localparam int DIV_BITS = DATA_WIDTH + FRAC_BITS;
  localparam int SQ_BITS  = (DATA_WIDTH + FRAC_BITS) / 2;
  localparam int SQ_REM   = SQ_BITS + 2;
  localparam int SQ_RAD   = 2 * SQ_BITS;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [2*DATA_WIDTH:0] wide_t;

  localparam word_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // per-word context carried alongside the datapath
  typedef struct packed {
    logic  vld;
    logic  deg;
    logic  az_neg;
    logic  mx_neg;
    word_t ax;
    word_t ay;
    word_t mx;
    word_t my;
    word_t u0;
    word_t u1;
    word_t u2;
    word_t u3;
    word_t p0;
    word_t p1;
    word_t p2;
    word_t p3;
    word_t m0;
    word_t m3;
  } ctx_t;

  function automatic word_t fx_clamp(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'(VMAX);
    lo = wide_t'(VMIN);
    if (v > hi) return VMAX;
    if (v < lo) return VMIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic word_t fx_add(input word_t a, input word_t b);
    return fx_clamp(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t fx_sub(input word_t a, input word_t b);
    return fx_clamp(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic word_t fx_neg(input word_t a);
    return (a == VMIN) ? VMAX : -a;
  endfunction

  // floor(a*b / 2^FRAC_BITS), saturated
  function automatic word_t fx_mul(input word_t a, input word_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return fx_clamp(p >>> FRAC_BITS);
  endfunction

  // elaboration-time floor(sqrt(x * 2^FRAC_BITS))
  function automatic word_t const_sqrt(input wide_t x);
    wide_t n;
    wide_t r;
    wide_t t;
    n = x <<< FRAC_BITS;
    r = '0;
    for (int i = SQ_BITS - 1; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= n) r = t;
    end
    return r[DATA_WIDTH-1:0];
  endfunction

  localparam word_t ONE   = fx_clamp(wide_t'(1) <<< FRAC_BITS);
  localparam word_t TWO   = fx_clamp(wide_t'(2) <<< FRAC_BITS);
  localparam word_t SQRT2 = const_sqrt(wide_t'(TWO));

endpackage

// ----- rtl/amq_if.sv -----
// ----------------------------------------------------------------------------
// amq_if
// Valid/ready channels: sensor word in, attitude word out.
// ----------------------------------------------------------------------------
interface amq_in_if;
  logic           valid;
  logic           ready;
  amq_pkg::word_t accel_x;
  amq_pkg::word_t accel_y;
  amq_pkg::word_t accel_z;
  amq_pkg::word_t mag_x;
  amq_pkg::word_t mag_y;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, output ready);
endinterface

interface amq_out_if;
  logic           valid;
  logic           ready;
  amq_pkg::word_t q_w;
  amq_pkg::word_t q_x;
  amq_pkg::word_t q_y;
  amq_pkg::word_t q_z;
  logic           degenerate;

  modport source (output valid, q_w, q_x, q_y, q_z, degenerate, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, degenerate, output ready);
endinterface

// ----- rtl/accel_mag_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// accel_mag_to_quaternion
// Attitude quaternion from one accelerometer vector and magnetometer x/y.
// ----------------------------------------------------------------------------
// Fully pipelined: one word accepted per cycle while the output side does
// not stall. The pipeline depth comes from the chain of three square-root
// stages and two restoring divide stages, both one result bit per step,
// plus nine multiply/add register stages. Any stall on the output holds
// the whole pipeline; degenerate is set, with a zero quaternion, when any
// divisor or norm came out zero.
module accel_mag_to_quaternion (
  input logic       clk,
  input logic       rst_n,
  amq_in_if.sink    in_ch,
  amq_out_if.source out_ch
);

  logic          en;
  logic          out_vld;
  amq_pkg::ctx_t mid_ctx;

  assign en           = !out_vld || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_vld;

  amq_front u_front (
    .clk,
    .rst_n,
    .en,
    .vld_i (in_ch.valid),
    .ax    (in_ch.accel_x),
    .ay    (in_ch.accel_y),
    .az    (in_ch.accel_z),
    .mx    (in_ch.mag_x),
    .my    (in_ch.mag_y),
    .ctx_o (mid_ctx)
  );

  amq_back u_back (
    .clk,
    .rst_n,
    .en,
    .ctx_i      (mid_ctx),
    .vld_o      (out_vld),
    .q_w        (out_ch.q_w),
    .q_x        (out_ch.q_x),
    .q_y        (out_ch.q_y),
    .q_z        (out_ch.q_z),
    .degenerate (out_ch.degenerate)
  );

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.q_w == '0 && out_ch.q_x == '0 && out_ch.q_y == '0 && out_ch.q_z == '0)
    else $error("degenerate word with non-zero quaternion");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid straight after reset");

endmodule

// ----- rtl/amq_sqrt.sv -----
// ----------------------------------------------------------------------------
// amq_sqrt
// Pipelined fixed-point square root, one result bit per stage.
// ----------------------------------------------------------------------------
module amq_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  amq_pkg::word_t x,
  input  amq_pkg::ctx_t  ctx_i,
  output amq_pkg::word_t q,
  output amq_pkg::ctx_t  ctx_o
);

  typedef struct packed {
    logic [amq_pkg::SQ_REM-1:0]  rem;
    logic [amq_pkg::SQ_BITS-1:0] root;
    logic [amq_pkg::SQ_RAD-1:0]  rad;
    logic                        zr;
    amq_pkg::ctx_t               ctx;
  } sq_st_t;

  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t                     r;
    logic [amq_pkg::SQ_REM-1:0] rin;
    logic [amq_pkg::SQ_REM-1:0] trial;
    logic                       ge;
    r     = s;
    rin   = {s.rem[amq_pkg::SQ_REM-3:0], s.rad[amq_pkg::SQ_RAD-1 -: 2]};
    trial = {s.root, 2'b01};
    ge    = (rin >= trial);
    r.rem  = ge ? (rin - trial) : rin;
    r.root = {s.root[amq_pkg::SQ_BITS-2:0], ge};
    r.rad  = s.rad << 2;
    return r;
  endfunction

  sq_st_t         st_r [0:amq_pkg::SQ_BITS];
  sq_st_t         st0_nxt;
  amq_pkg::word_t q_r, q_nxt;
  amq_pkg::ctx_t  ctx_r;

  always_comb begin
    st0_nxt      = '0;
    st0_nxt.zr   = x[amq_pkg::DATA_WIDTH-1] || (x == '0);
    st0_nxt.rad[amq_pkg::DATA_WIDTH+amq_pkg::FRAC_BITS-2:0] =
      {x[amq_pkg::DATA_WIDTH-2:0], {amq_pkg::FRAC_BITS{1'b0}}};
    st0_nxt.ctx  = ctx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].ctx.vld <= 1'b0;
    end else if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 1; k <= amq_pkg::SQ_BITS; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].ctx.vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= sq_step(st_r[k-1]);
      end
    end
  end

  always_comb begin
    q_nxt = '0;
    if (!st_r[amq_pkg::SQ_BITS].zr) begin
      q_nxt[amq_pkg::SQ_BITS-1:0] = st_r[amq_pkg::SQ_BITS].root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.vld <= 1'b0;
    end else if (en) begin
      ctx_r <= st_r[amq_pkg::SQ_BITS].ctx;
      q_r   <= q_nxt;
    end
  end

  assign q     = q_r;
  assign ctx_o = ctx_r;

endmodule

// ----- rtl/amq_div.sv -----
// ----------------------------------------------------------------------------
// amq_div
// Pipelined signed fixed-point divide, restoring, one quotient bit per stage.
// Zero divisor gives 0 and raises dz.
// ----------------------------------------------------------------------------
module amq_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  amq_pkg::word_t a,
  input  amq_pkg::word_t b,
  input  amq_pkg::ctx_t  ctx_i,
  output amq_pkg::word_t q,
  output logic           dz,
  output amq_pkg::ctx_t  ctx_o
);

  typedef struct packed {
    logic [amq_pkg::DATA_WIDTH-1:0] rem;
    logic [amq_pkg::DIV_BITS-1:0]   nq;
    logic [amq_pkg::DATA_WIDTH-1:0] dv;
    logic                           neg;
    logic                           dz;
    amq_pkg::ctx_t                  ctx;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t                      r;
    logic [amq_pkg::DATA_WIDTH:0] trial;
    logic [amq_pkg::DATA_WIDTH:0] diff;
    logic                         ge;
    r     = s;
    trial = {s.rem, s.nq[amq_pkg::DIV_BITS-1]};
    ge    = (trial >= {1'b0, s.dv});
    diff  = trial - {1'b0, s.dv};
    r.rem = ge ? diff[amq_pkg::DATA_WIDTH-1:0] : trial[amq_pkg::DATA_WIDTH-1:0];
    r.nq  = {s.nq[amq_pkg::DIV_BITS-2:0], ge};
    return r;
  endfunction

  div_st_t                        st_r [0:amq_pkg::DIV_BITS];
  div_st_t                        st0_nxt;
  logic [amq_pkg::DATA_WIDTH-1:0] ma, mb;
  logic [amq_pkg::DIV_BITS-1:0]   qv;
  amq_pkg::word_t                 q_r, q_nxt;
  logic                           dz_r;
  amq_pkg::ctx_t                  ctx_r;

  always_comb begin
    ma          = a[amq_pkg::DATA_WIDTH-1] ? (~a + 1'b1) : a;
    mb          = b[amq_pkg::DATA_WIDTH-1] ? (~b + 1'b1) : b;
    st0_nxt.rem = '0;
    st0_nxt.nq  = {ma, {amq_pkg::FRAC_BITS{1'b0}}};
    st0_nxt.dv  = mb;
    st0_nxt.neg = a[amq_pkg::DATA_WIDTH-1] ^ b[amq_pkg::DATA_WIDTH-1];
    st0_nxt.dz  = (b == '0);
    st0_nxt.ctx = ctx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].ctx.vld <= 1'b0;
    end else if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 1; k <= amq_pkg::DIV_BITS; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].ctx.vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  // saturate the magnitude back to a signed word
  always_comb begin
    qv = st_r[amq_pkg::DIV_BITS].nq;
    if (st_r[amq_pkg::DIV_BITS].dz) begin
      q_nxt = '0;
    end else if (st_r[amq_pkg::DIV_BITS].neg) begin
      if (qv > {{amq_pkg::FRAC_BITS{1'b0}}, amq_pkg::VMAX}) q_nxt = amq_pkg::VMIN;
      else q_nxt = ~qv[amq_pkg::DATA_WIDTH-1:0] + 1'b1;
    end else begin
      if (qv > {{amq_pkg::FRAC_BITS{1'b0}}, amq_pkg::VMAX}) q_nxt = amq_pkg::VMAX;
      else q_nxt = qv[amq_pkg::DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.vld <= 1'b0;
    end else if (en) begin
      ctx_r <= st_r[amq_pkg::DIV_BITS].ctx;
      q_r   <= q_nxt;
      dz_r  <= st_r[amq_pkg::DIV_BITS].dz;
    end
  end

  assign q     = q_r;
  assign dz    = dz_r;
  assign ctx_o = ctx_r;

endmodule

// ----- rtl/amq_front.sv -----
// ----------------------------------------------------------------------------
// amq_front
// Tilt quaternion from the accelerometer and heading quaternion from the
// magnetometer, both before normalisation.
// ----------------------------------------------------------------------------
module amq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  amq_pkg::word_t ax,
  input  amq_pkg::word_t ay,
  input  amq_pkg::word_t az,
  input  amq_pkg::word_t mx,
  input  amq_pkg::word_t my,
  output amq_pkg::ctx_t  ctx_o
);

  amq_pkg::ctx_t  f1_r, f1_nxt, f2_r, f2_nxt, f3_r, f3_nxt;
  amq_pkg::ctx_t  f4_r, f4_nxt, f5_r, f5_nxt, f6_r, f6_nxt;
  amq_pkg::ctx_t  sqa_ctx, sqb_ctx, dva_ctx;
  amq_pkg::word_t s_w, tau_w;
  amq_pkg::word_t d_w, a0_w, rt_w, t2_w, sg_w;
  amq_pkg::word_t qy_w, qx_w, na_w, nb_w;
  logic           dz_y, dz_x, dz_a, dz_b;

  // s = 1 +- az, mag products
  always_comb begin
    s_w = az[amq_pkg::DATA_WIDTH-1] ? amq_pkg::fx_sub(amq_pkg::ONE, az)
                                    : amq_pkg::fx_add(az, amq_pkg::ONE);
    f1_nxt        = '0;
    f1_nxt.vld    = vld_i;
    f1_nxt.az_neg = az[amq_pkg::DATA_WIDTH-1];
    f1_nxt.mx_neg = mx[amq_pkg::DATA_WIDTH-1];
    f1_nxt.ax     = ax;
    f1_nxt.ay     = ay;
    f1_nxt.mx     = mx;
    f1_nxt.my     = my;
    f1_nxt.u0     = amq_pkg::fx_mul(amq_pkg::TWO, s_w);
    f1_nxt.u1     = s_w >>> 1;
    f1_nxt.u2     = amq_pkg::fx_mul(mx, mx);
    f1_nxt.u3     = amq_pkg::fx_mul(my, my);
  end

  always_comb begin
    tau_w     = amq_pkg::fx_add(f1_r.u2, f1_r.u3);
    f2_nxt    = f1_r;
    f2_nxt.u2 = tau_w;
    f2_nxt.u3 = amq_pkg::fx_mul(amq_pkg::TWO, tau_w);
  end

  amq_sqrt u_sq_d  (.clk, .rst_n, .en, .x(f2_r.u0), .ctx_i(f2_r), .q(d_w),  .ctx_o(sqa_ctx));
  amq_sqrt u_sq_h  (.clk, .rst_n, .en, .x(f2_r.u1), .ctx_i('0),   .q(a0_w), .ctx_o());
  amq_sqrt u_sq_rt (.clk, .rst_n, .en, .x(f2_r.u2), .ctx_i('0),   .q(rt_w), .ctx_o());
  amq_sqrt u_sq_t2 (.clk, .rst_n, .en, .x(f2_r.u3), .ctx_i('0),   .q(t2_w), .ctx_o());

  always_comb begin
    f3_nxt    = sqa_ctx;
    f3_nxt.u0 = d_w;
    f3_nxt.u1 = a0_w;
    f3_nxt.u3 = t2_w;
    f3_nxt.p0 = amq_pkg::fx_mul(sqa_ctx.mx, rt_w);
  end

  always_comb begin
    f4_nxt    = f3_r;
    f4_nxt.p0 = f3_r.mx_neg ? amq_pkg::fx_sub(f3_r.u2, f3_r.p0)
                            : amq_pkg::fx_add(f3_r.u2, f3_r.p0);
  end

  amq_sqrt u_sq_g (.clk, .rst_n, .en, .x(f4_r.p0), .ctx_i(f4_r), .q(sg_w), .ctx_o(sqb_ctx));

  always_comb begin
    f5_nxt    = sqb_ctx;
    f5_nxt.p1 = sg_w;
    f5_nxt.p2 = amq_pkg::fx_mul(amq_pkg::SQRT2, sg_w);
  end

  amq_div u_dv_y (.clk, .rst_n, .en, .a(f5_r.ay), .b(f5_r.u0), .ctx_i(f5_r),
                  .q(qy_w), .dz(dz_y), .ctx_o(dva_ctx));
  amq_div u_dv_x (.clk, .rst_n, .en, .a(f5_r.ax), .b(f5_r.u0), .ctx_i('0),
                  .q(qx_w), .dz(dz_x), .ctx_o());
  amq_div u_dv_a (.clk, .rst_n, .en, .a(f5_r.p1), .b(f5_r.u3), .ctx_i('0),
                  .q(na_w), .dz(dz_a), .ctx_o());
  amq_div u_dv_b (.clk, .rst_n, .en, .a(f5_r.my), .b(f5_r.p2), .ctx_i('0),
                  .q(nb_w), .dz(dz_b), .ctx_o());

  always_comb begin
    f6_nxt     = dva_ctx;
    f6_nxt.deg = dva_ctx.deg | dz_y | dz_x | dz_a | dz_b;
    if (dva_ctx.az_neg) begin
      f6_nxt.p0 = amq_pkg::fx_neg(qy_w);
      f6_nxt.p1 = dva_ctx.u1;
      f6_nxt.p2 = '0;
      f6_nxt.p3 = qx_w;
    end else begin
      f6_nxt.p0 = dva_ctx.u1;
      f6_nxt.p1 = amq_pkg::fx_neg(qy_w);
      f6_nxt.p2 = qx_w;
      f6_nxt.p3 = '0;
    end
    f6_nxt.m0 = dva_ctx.mx_neg ? nb_w : na_w;
    f6_nxt.m3 = dva_ctx.mx_neg ? na_w : nb_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld <= 1'b0;
      f2_r.vld <= 1'b0;
      f3_r.vld <= 1'b0;
      f4_r.vld <= 1'b0;
      f5_r.vld <= 1'b0;
      f6_r.vld <= 1'b0;
    end else if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
      f4_r <= f4_nxt;
      f5_r <= f5_nxt;
      f6_r <= f6_nxt;
    end
  end

  assign ctx_o = f6_r;

endmodule

// ----- rtl/amq_back.sv -----
// ----------------------------------------------------------------------------
// amq_back
// Normalises both quaternions and joins them with a Hamilton product.
// Holds the output register.
// ----------------------------------------------------------------------------
module amq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  amq_pkg::ctx_t  ctx_i,
  output logic           vld_o,
  output amq_pkg::word_t q_w,
  output amq_pkg::word_t q_x,
  output amq_pkg::word_t q_y,
  output amq_pkg::word_t q_z,
  output logic           degenerate
);

  amq_pkg::ctx_t  b1_r, b1_nxt, b2_r, b2_nxt, sq_ctx, dv_ctx;
  amq_pkg::word_t na_w, nm_w, n0_w, n1_w, n2_w, n3_w, k0_w, k3_w;
  logic [5:0]     dz;
  logic           vld_r;
  logic           deg_r;
  amq_pkg::word_t q_w_r, q_x_r, q_y_r, q_z_r;

  // squares are never negative, so one clamp of the full sum is exact
  always_comb begin
    b1_nxt    = ctx_i;
    b1_nxt.u0 = amq_pkg::fx_clamp(
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.p0, ctx_i.p0)) +
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.p1, ctx_i.p1)) +
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.p2, ctx_i.p2)) +
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.p3, ctx_i.p3)));
    b1_nxt.u1 = amq_pkg::fx_clamp(
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.m0, ctx_i.m0)) +
                  amq_pkg::wide_t'(amq_pkg::fx_mul(ctx_i.m3, ctx_i.m3)));
  end

  amq_sqrt u_sq_a (.clk, .rst_n, .en, .x(b1_r.u0), .ctx_i(b1_r), .q(na_w), .ctx_o(sq_ctx));
  amq_sqrt u_sq_m (.clk, .rst_n, .en, .x(b1_r.u1), .ctx_i('0),   .q(nm_w), .ctx_o());

  amq_div u_dv_0 (.clk, .rst_n, .en, .a(sq_ctx.p0), .b(na_w), .ctx_i(sq_ctx),
                  .q(n0_w), .dz(dz[0]), .ctx_o(dv_ctx));
  amq_div u_dv_1 (.clk, .rst_n, .en, .a(sq_ctx.p1), .b(na_w), .ctx_i('0),
                  .q(n1_w), .dz(dz[1]), .ctx_o());
  amq_div u_dv_2 (.clk, .rst_n, .en, .a(sq_ctx.p2), .b(na_w), .ctx_i('0),
                  .q(n2_w), .dz(dz[2]), .ctx_o());
  amq_div u_dv_3 (.clk, .rst_n, .en, .a(sq_ctx.p3), .b(na_w), .ctx_i('0),
                  .q(n3_w), .dz(dz[3]), .ctx_o());
  amq_div u_dv_4 (.clk, .rst_n, .en, .a(sq_ctx.m0), .b(nm_w), .ctx_i('0),
                  .q(k0_w), .dz(dz[4]), .ctx_o());
  amq_div u_dv_5 (.clk, .rst_n, .en, .a(sq_ctx.m3), .b(nm_w), .ctx_i('0),
                  .q(k3_w), .dz(dz[5]), .ctx_o());

  // heading has no x or y part, so half the Hamilton terms vanish
  always_comb begin
    b2_nxt     = dv_ctx;
    b2_nxt.deg = dv_ctx.deg | (|dz);
    b2_nxt.u0  = amq_pkg::fx_mul(n0_w, k0_w);
    b2_nxt.u1  = amq_pkg::fx_mul(n3_w, k3_w);
    b2_nxt.u2  = amq_pkg::fx_mul(n1_w, k0_w);
    b2_nxt.u3  = amq_pkg::fx_mul(n2_w, k3_w);
    b2_nxt.p0  = amq_pkg::fx_mul(n2_w, k0_w);
    b2_nxt.p1  = amq_pkg::fx_mul(n1_w, k3_w);
    b2_nxt.p2  = amq_pkg::fx_mul(n3_w, k0_w);
    b2_nxt.p3  = amq_pkg::fx_mul(n0_w, k3_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.vld <= 1'b0;
      b2_r.vld <= 1'b0;
      vld_r    <= 1'b0;
    end else if (en) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      vld_r <= b2_r.vld;
      deg_r <= b2_r.deg;
      q_w_r <= b2_r.deg ? '0 : amq_pkg::fx_sub(b2_r.u0, b2_r.u1);
      q_x_r <= b2_r.deg ? '0 : amq_pkg::fx_add(b2_r.u2, b2_r.u3);
      q_y_r <= b2_r.deg ? '0 : amq_pkg::fx_sub(b2_r.p0, b2_r.p1);
      q_z_r <= b2_r.deg ? '0 : amq_pkg::fx_add(b2_r.p2, b2_r.p3);
    end
  end

  assign vld_o      = vld_r;
  assign degenerate = deg_r;
  assign q_w        = q_w_r;
  assign q_x        = q_x_r;
  assign q_y        = q_y_r;
  assign q_z        = q_z_r;

endmodule
